// ===== rtl/foreground_bounding_box_3d_core_macros.svh =====
// Assertion helpers for the bounding box core.
// Both forms expect clk and rst_n in scope.
`ifndef FOREGROUND_BOUNDING_BOX_3D_CORE_MACROS_SVH
`define FOREGROUND_BOUNDING_BOX_3D_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define FBB3D_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounding box core check failed");
`define FBB3D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounding box core check failed");
`else
`define FBB3D_ASSERT_SAME(label, ante, cons)
`define FBB3D_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/fbb3d_pkg.sv =====
package fbb3d_pkg;

    localparam int CoordBits    = 12;
    localparam int LenBits      = CoordBits + 1;
    localparam int ExtentBits   = 13;
    localparam int SampleBits   = 16;
    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits  = 16;
    localparam int CmpBits      = ((LenBits > ExtentBits) ? LenBits : ExtentBits) + 1;
    localparam int SumBits      = LenBits + 1;

    localparam logic                         ModeReset      = 1'b1;
    localparam logic signed [SampleBits-1:0] ThresholdReset = -16'sd1200;
    localparam logic [ExtentBits-1:0]        ExtentXReset   = 13'd512;
    localparam logic [ExtentBits-1:0]        ExtentYReset   = 13'd512;
    localparam logic [ExtentBits-1:0]        ExtentZReset   = 13'd256;

    typedef enum logic [CfgIndexBits-1:0] {
        REG_SELECT_MODE = 3'd0,
        REG_THRESHOLD   = 3'd1,
        REG_EXTENT_X    = 3'd2,
        REG_EXTENT_Y    = 3'd3,
        REG_EXTENT_Z    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CoordBits-1:0] origin;
        logic [LenBits-1:0]   length;
    } axis_t;

    // Origin and length of one axis, with the optional one-voxel margin.
    function automatic axis_t axis_out(
        input logic [CoordBits-1:0]  lo,
        input logic [CoordBits-1:0]  hi,
        input logic [ExtentBits-1:0] extent,
        input logic                  margin
    );
        axis_t              res;
        logic [SumBits-1:0] n;
        logic [CmpBits-1:0] box_end;
        n       = SumBits'(hi) - SumBits'(lo) + SumBits'(1);
        box_end = CmpBits'(hi) + CmpBits'(1);
        res.origin = lo;
        if (margin)
        begin
            if (lo != '0)
            begin
                res.origin = lo - CoordBits'(1);
                n          = n + SumBits'(1);
            end
            // origin plus length is unchanged by the lower margin
            if (box_end < CmpBits'(extent))
            begin
                n = n + SumBits'(1);
            end
        end
        res.length = n[LenBits-1:0];
        return res;
    endfunction

endpackage

// ===== rtl/fbb3d_if.sv =====
interface fbb3d_voxel_if
    import fbb3d_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic [CoordBits-1:0]         voxel_x;
    logic [CoordBits-1:0]         voxel_y;
    logic [CoordBits-1:0]         voxel_z;
    logic signed [SampleBits-1:0] sample;
    logic                         last_voxel;

    modport source (output valid, voxel_x, voxel_y, voxel_z, sample, last_voxel,
                    input ready);
    modport sink   (input valid, voxel_x, voxel_y, voxel_z, sample, last_voxel,
                    output ready);
endinterface

interface fbb3d_box_if
    import fbb3d_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CoordBits-1:0] origin_x;
    logic [CoordBits-1:0] origin_y;
    logic [CoordBits-1:0] origin_z;
    logic [LenBits-1:0]   length_x;
    logic [LenBits-1:0]   length_y;
    logic [LenBits-1:0]   length_z;
    logic                 region_empty;

    modport source (output valid, origin_x, origin_y, origin_z,
                    length_x, length_y, length_z, region_empty,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z,
                    length_x, length_y, length_z, region_empty,
                    output ready);
endinterface

interface fbb3d_cfg_if
    import fbb3d_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CfgIndexBits-1:0] index;
    logic [CfgDataBits-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/foreground_bounding_box_3d_core.sv =====
// Result path: a last voxel is held in the input register, then its box goes
// to the result register. Throughput: one voxel per cycle unless a last voxel
// waits for a result register still held, which stalls the input; the input
// register and the box update otherwise take a new voxel each cycle.
// Reset (rst_n, async, active low): box empty, pipeline empty, registers at
// mask/threshold mode 1, threshold -1200, extents 512, 512, 256.
`include "foreground_bounding_box_3d_core_macros.svh"

module foreground_bounding_box_3d_core
    import fbb3d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fbb3d_voxel_if.sink voxel,
    fbb3d_box_if.source box,
    fbb3d_cfg_if.sink   cfg
);

    logic                         mode_reg;
    logic signed [SampleBits-1:0] threshold_reg;
    logic [ExtentBits-1:0]        extent_x_reg;
    logic [ExtentBits-1:0]        extent_y_reg;
    logic [ExtentBits-1:0]        extent_z_reg;

    logic                         s1_valid_reg;
    logic [CoordBits-1:0]         s1_x_reg;
    logic [CoordBits-1:0]         s1_y_reg;
    logic [CoordBits-1:0]         s1_z_reg;
    logic signed [SampleBits-1:0] s1_sample_reg;
    logic                         s1_last_reg;

    logic [CoordBits-1:0] low_x_reg, low_y_reg, low_z_reg;
    logic [CoordBits-1:0] high_x_reg, high_y_reg, high_z_reg;
    logic                 seen_any_reg;
    logic [CoordBits-1:0] low_x_next, low_y_next, low_z_next;
    logic [CoordBits-1:0] high_x_next, high_y_next, high_z_next;
    logic                 seen_any_next;

    logic                 out_valid_reg;
    axis_t                out_x_reg, out_y_reg, out_z_reg;
    logic                 out_empty_reg;

    logic  s1_advance;
    logic  s1_fire;
    logic  fg;
    axis_t axis_x, axis_y, axis_z;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ModeReset;
            threshold_reg <= ThresholdReset;
            extent_x_reg  <= ExtentXReset;
            extent_y_reg  <= ExtentYReset;
            extent_z_reg  <= ExtentZReset;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SELECT_MODE: mode_reg      <= cfg.data[0];
                REG_THRESHOLD:   threshold_reg <= $signed(cfg.data[SampleBits-1:0]);
                REG_EXTENT_X:    extent_x_reg  <= cfg.data[ExtentBits-1:0];
                REG_EXTENT_Y:    extent_y_reg  <= cfg.data[ExtentBits-1:0];
                REG_EXTENT_Z:    extent_z_reg  <= cfg.data[ExtentBits-1:0];
                default:         ;
            endcase
        end
    end

    // A plain voxel always moves on; a last voxel needs the result slot free.
    assign s1_advance  = !s1_last_reg || !out_valid_reg || box.ready;
    assign s1_fire     = s1_valid_reg && s1_advance;
    assign voxel.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (voxel.ready)
        begin
            s1_valid_reg <= voxel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (voxel.valid && voxel.ready)
        begin
            s1_x_reg      <= voxel.voxel_x;
            s1_y_reg      <= voxel.voxel_y;
            s1_z_reg      <= voxel.voxel_z;
            s1_sample_reg <= voxel.sample;
            s1_last_reg   <= voxel.last_voxel;
        end
    end

    always_comb
    begin
        if (mode_reg)
        begin
            fg = s1_sample_reg > threshold_reg;
        end
        else
        begin
            fg = s1_sample_reg != '0;
        end

        low_x_next    = low_x_reg;
        low_y_next    = low_y_reg;
        low_z_next    = low_z_reg;
        high_x_next   = high_x_reg;
        high_y_next   = high_y_reg;
        high_z_next   = high_z_reg;
        seen_any_next = seen_any_reg;
        if (fg)
        begin
            seen_any_next = 1'b1;
            if (!seen_any_reg || s1_x_reg < low_x_reg)  low_x_next  = s1_x_reg;
            if (!seen_any_reg || s1_x_reg > high_x_reg) high_x_next = s1_x_reg;
            if (!seen_any_reg || s1_y_reg < low_y_reg)  low_y_next  = s1_y_reg;
            if (!seen_any_reg || s1_y_reg > high_y_reg) high_y_next = s1_y_reg;
            if (!seen_any_reg || s1_z_reg < low_z_reg)  low_z_next  = s1_z_reg;
            if (!seen_any_reg || s1_z_reg > high_z_reg) high_z_next = s1_z_reg;
        end

        axis_x = axis_out(low_x_next, high_x_next, extent_x_reg, mode_reg);
        axis_y = axis_out(low_y_next, high_y_next, extent_y_reg, mode_reg);
        axis_z = axis_out(low_z_next, high_z_next, extent_z_reg, mode_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_x_reg    <= '0;
            low_y_reg    <= '0;
            low_z_reg    <= '0;
            high_x_reg   <= '0;
            high_y_reg   <= '0;
            high_z_reg   <= '0;
            seen_any_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                // drop the box for the next volume
                low_x_reg    <= '0;
                low_y_reg    <= '0;
                low_z_reg    <= '0;
                high_x_reg   <= '0;
                high_y_reg   <= '0;
                high_z_reg   <= '0;
                seen_any_reg <= 1'b0;
            end
            else
            begin
                low_x_reg    <= low_x_next;
                low_y_reg    <= low_y_next;
                low_z_reg    <= low_z_next;
                high_x_reg   <= high_x_next;
                high_y_reg   <= high_y_next;
                high_z_reg   <= high_z_next;
                seen_any_reg <= seen_any_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (box.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_empty_reg <= !seen_any_next;
            if (seen_any_next)
            begin
                out_x_reg <= axis_x;
                out_y_reg <= axis_y;
                out_z_reg <= axis_z;
            end
            else
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_z_reg <= '0;
            end
        end
    end

    assign box.valid        = out_valid_reg;
    assign box.origin_x     = out_x_reg.origin;
    assign box.origin_y     = out_y_reg.origin;
    assign box.origin_z     = out_z_reg.origin;
    assign box.length_x     = out_x_reg.length;
    assign box.length_y     = out_y_reg.length;
    assign box.length_z     = out_z_reg.length;
    assign box.region_empty = out_empty_reg;

    `FBB3D_ASSERT_SAME(a_empty_zero, out_valid_reg && out_empty_reg,
        box.origin_x == '0 && box.origin_y == '0 && box.origin_z == '0 &&
        box.length_x == '0 && box.length_y == '0 && box.length_z == '0)
    `FBB3D_ASSERT_SAME(a_box_nonzero, out_valid_reg && !out_empty_reg,
        box.length_x != '0 && box.length_y != '0 && box.length_z != '0)
    `FBB3D_ASSERT_NEXT(a_clear_after_last, s1_fire && s1_last_reg, !seen_any_reg)
    `FBB3D_ASSERT_SAME(a_box_ordered, seen_any_reg,
        low_x_reg <= high_x_reg && low_y_reg <= high_y_reg && low_z_reg <= high_z_reg)

endmodule

// ===== test/tb_foreground_bounding_box_3d_core.sv =====
module tb_foreground_bounding_box_3d_core
    import fbb3d_pkg::*;
;

    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [CoordBits-1:0] origin_x;
        logic [CoordBits-1:0] origin_y;
        logic [CoordBits-1:0] origin_z;
        logic [LenBits-1:0]   length_x;
        logic [LenBits-1:0]   length_y;
        logic [LenBits-1:0]   length_z;
        logic                 region_empty;
    } box_t;

    logic clk = 1'b0;
    logic rst_n;

    fbb3d_voxel_if voxel_ch ();
    fbb3d_box_if   box_ch ();
    fbb3d_cfg_if   cfg_ch ();

    foreground_bounding_box_3d_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .voxel (voxel_ch),
        .box   (box_ch),
        .cfg   (cfg_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // register copies held by the predictor
    logic                         cfg_mode = ModeReset;
    logic signed [SampleBits-1:0] cfg_thr  = ThresholdReset;
    logic [ExtentBits-1:0]        cfg_ext [3] = '{ExtentXReset, ExtentYReset, ExtentZReset};

    // running box of the volume in flight
    logic [CoordBits-1:0] box_lo [3] = '{default: '0};
    logic [CoordBits-1:0] box_hi [3] = '{default: '0};
    logic                 box_seen = 1'b0;

    box_t boxes_due [$];
    int   mismatches   = 0;
    int   voxels_sent  = 0;
    int   src_idle_pct = 0;
    int   sink_idle_pct = 0;
    logic sink_hold = 1'b0;
    event stall_go;

    function automatic void axis_bounds(input logic [CoordBits-1:0] lo,
                                        input logic [CoordBits-1:0] hi,
                                        input logic [ExtentBits-1:0] ext,
                                        input logic margin,
                                        output logic [CoordBits-1:0] org,
                                        output logic [LenBits-1:0] len);
        int o;
        int n;
        o = int'(lo);
        n = int'(hi) - int'(lo) + 1;
        if (margin)
        begin
            if (o > 0)
            begin
                o = o - 1;
                n = n + 1;
            end
            // box end is hi + 1 regardless of the lower margin
            if (o + n < int'(ext))
                n = n + 1;
        end
        org = o[CoordBits-1:0];
        len = n[LenBits-1:0];
    endfunction

    // Fold one accepted voxel into the box; queue the box on the last voxel.
    function automatic void track_voxel(input logic [CoordBits-1:0] x,
                                        input logic [CoordBits-1:0] y,
                                        input logic [CoordBits-1:0] z,
                                        input logic signed [SampleBits-1:0] s,
                                        input logic last);
        logic [CoordBits-1:0] c [3];
        logic                 fg;
        box_t                 res;
        c[0] = x;
        c[1] = y;
        c[2] = z;
        fg = cfg_mode ? (s > cfg_thr) : (s != 0);
        if (fg)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (!box_seen || c[a] < box_lo[a])
                    box_lo[a] = c[a];
                if (!box_seen || c[a] > box_hi[a])
                    box_hi[a] = c[a];
            end
            box_seen = 1'b1;
        end
        if (!last)
            return;
        res = '0;
        if (!box_seen)
            res.region_empty = 1'b1;
        else
        begin
            axis_bounds(box_lo[0], box_hi[0], cfg_ext[0], cfg_mode, res.origin_x, res.length_x);
            axis_bounds(box_lo[1], box_hi[1], cfg_ext[1], cfg_mode, res.origin_y, res.length_y);
            axis_bounds(box_lo[2], box_hi[2], cfg_ext[2], cfg_mode, res.origin_z, res.length_z);
        end
        boxes_due.push_back(res);
        box_lo   = '{default: '0};
        box_hi   = '{default: '0};
        box_seen = 1'b0;
    endfunction

    // Offer one voxel request and hold it until the block takes it.
    task automatic send_voxel(input logic [CoordBits-1:0] x,
                              input logic [CoordBits-1:0] y,
                              input logic [CoordBits-1:0] z,
                              input logic signed [SampleBits-1:0] s,
                              input logic last);
        if ($urandom_range(99) < src_idle_pct)
        begin
            voxel_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        voxel_ch.valid      <= 1'b1;
        voxel_ch.voxel_x    <= x;
        voxel_ch.voxel_y    <= y;
        voxel_ch.voxel_z    <= z;
        voxel_ch.sample     <= s;
        voxel_ch.last_voxel <= last;
        do
            @(posedge clk);
        while (!voxel_ch.ready);
        track_voxel(x, y, z, s, last);
        voxels_sent++;
    endtask

    // Drop valid, wait for every queued box, then let the pipeline settle.
    task automatic drain;
        voxel_ch.valid <= 1'b0;
        while (boxes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataBits-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_SELECT_MODE: cfg_mode   = val[0];
            REG_THRESHOLD:   cfg_thr    = val;
            REG_EXTENT_X:    cfg_ext[0] = val[ExtentBits-1:0];
            REG_EXTENT_Y:    cfg_ext[1] = val[ExtentBits-1:0];
            REG_EXTENT_Z:    cfg_ext[2] = val[ExtentBits-1:0];
            default: ;
        endcase
    endtask

    // Call only with the block idle.
    task automatic program_regs(input logic mode, input logic signed [SampleBits-1:0] thr,
                                input logic [ExtentBits-1:0] ex,
                                input logic [ExtentBits-1:0] ey,
                                input logic [ExtentBits-1:0] ez);
        write_reg(REG_SELECT_MODE, {15'd0, mode});
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_EXTENT_X, {3'd0, ex});
        write_reg(REG_EXTENT_Y, {3'd0, ey});
        write_reg(REG_EXTENT_Z, {3'd0, ez});
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [CoordBits-1:0] pick_coord(input logic [ExtentBits-1:0] ext);
        if (ext <= 13'd4096 && $urandom_range(3) != 0)
            return CoordBits'($urandom_range(int'(ext) - 1));
        return CoordBits'($urandom_range(4095));
    endfunction

    function automatic logic signed [SampleBits-1:0] pick_sample(input logic background);
        int v;
        if (background)
        begin
            if (!cfg_mode)
                return '0;
            v = int'(cfg_thr) - int'($urandom_range(4));
        end
        else if (cfg_mode)
        begin
            case ($urandom_range(3))
                0, 1:    v = int'(cfg_thr) + int'($urandom_range(6)) - 3;
                2:       v = int'($urandom_range(65535)) - 32768;
                default: v = int'($urandom_range(32767));
            endcase
        end
        else
        begin
            case ($urandom_range(3))
                0:       v = 0;
                1:       v = $urandom_range(1) ? 1 : -1;
                default: v = int'($urandom_range(65535)) - 32768;
            endcase
        end
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return SampleBits'(v);
    endfunction

    task automatic send_volume(input int n);
        logic background;
        background = ($urandom_range(9) == 0);
        for (int i = 0; i < n; i++)
            send_voxel(pick_coord(cfg_ext[0]), pick_coord(cfg_ext[1]), pick_coord(cfg_ext[2]),
                       pick_sample(background), i == n - 1);
    endtask

    function automatic logic [ExtentBits-1:0] pick_extent();
        case ($urandom_range(5))
            0:       return 13'd1;
            1:       return 13'd4096;
            2:       return 13'd8191;
            3:       return ExtentBits'($urandom_range(64, 1));
            default: return ExtentBits'($urandom_range(4096, 1));
        endcase
    endfunction

    function automatic logic signed [SampleBits-1:0] pick_threshold();
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return SampleBits'($urandom_range(65535));
        endcase
    endfunction

    task automatic test_reset_defaults;
        send_voxel(12'd9, 12'd9, 12'd9, -16'sd1200, 1'b1);
        send_voxel(12'd0, 12'd0, 12'd0, -16'sd1199, 1'b0);
        send_voxel(12'd511, 12'd511, 12'd255, 16'sd32767, 1'b1);
        send_voxel(12'd5, 12'd6, 12'd7, 16'sd100, 1'b1);
        drain();
    endtask

    task automatic test_mask_mode;
        program_regs(1'b0, 16'sd0, 13'd4096, 13'd4096, 13'd4096);
        send_voxel(12'd4095, 12'd4095, 12'd4095, 16'sh8000, 1'b0);
        send_voxel(12'd0, 12'd0, 12'd0, 16'sd0, 1'b0);
        send_voxel(12'd1, 12'd0, 12'd2, 16'sd1, 1'b0);
        send_voxel(12'd2048, 12'd2048, 12'd2048, 16'sd0, 1'b1);
        send_voxel(12'd3, 12'd3, 12'd3, 16'sd0, 1'b1);
        drain();
    endtask

    task automatic test_threshold_extremes;
        program_regs(1'b1, 16'sh7fff, 13'd1, 13'd1, 13'd1);
        send_voxel(12'd4095, 12'd0, 12'd4095, 16'sh7fff, 1'b1);
        drain();
        program_regs(1'b1, 16'sh8000, 13'd1, 13'd1, 13'd1);
        send_voxel(12'd0, 12'd0, 12'd0, 16'sh8000, 1'b0);
        // outside the extent: taken as given, no upper margin
        send_voxel(12'd3, 12'd3, 12'd3, 16'sh8001, 1'b1);
        send_voxel(12'd0, 12'd0, 12'd0, 16'sh8001, 1'b1);
        drain();
    endtask

    task automatic test_large_extent;
        program_regs(1'b1, 16'sh8000, 13'd8191, 13'd8191, 13'd4096);
        send_voxel(12'd0, 12'd0, 12'd0, 16'sd0, 1'b0);
        send_voxel(12'd4095, 12'd4095, 12'd4095, 16'sd0, 1'b1);
        send_voxel(12'd1, 12'd4094, 12'd4094, 16'sd5, 1'b0);
        send_voxel(12'd4094, 12'd1, 12'd1, 16'sd5, 1'b1);
        drain();
    endtask

    task automatic test_random(input int n_voxels);
        int target;
        int chunk;
        target = voxels_sent + n_voxels;
        while (voxels_sent < target)
        begin
            drain();
            program_regs(1'($urandom_range(1)), pick_threshold(),
                         pick_extent(), pick_extent(), pick_extent());
            chunk = voxels_sent + $urandom_range(140, 60);
            while (voxels_sent < chunk)
                send_volume(($urandom_range(4) == 0) ? $urandom_range(40, 9)
                                                     : $urandom_range(8, 1));
        end
        drain();
    endtask

    // Hold the sink while volumes keep coming so the block stalls its input.
    task automatic test_backpressure;
        drain();
        program_regs(1'b1, pick_threshold(), pick_extent(), pick_extent(), pick_extent());
        -> stall_go;
        for (int i = 0; i < 30; i++)
            send_volume($urandom_range(3, 1));
        drain();
    endtask

    always
    begin
        @(stall_go);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        box_t got;
        box_t want;
        if (rst_n && box_ch.valid && box_ch.ready)
        begin
            got = '{box_ch.origin_x, box_ch.origin_y, box_ch.origin_z,
                    box_ch.length_x, box_ch.length_y, box_ch.length_z,
                    box_ch.region_empty};
            if (boxes_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected box: org %0d %0d %0d len %0d %0d %0d empty %0b",
                             got.origin_x, got.origin_y, got.origin_z,
                             got.length_x, got.length_y, got.length_z, got.region_empty);
                mismatches++;
            end
            else
            begin
                want = boxes_due.pop_front();
                if (got.origin_x !== want.origin_x || got.origin_y !== want.origin_y ||
                    got.origin_z !== want.origin_z || got.length_x !== want.length_x ||
                    got.length_y !== want.length_y || got.length_z !== want.length_z ||
                    got.region_empty !== want.region_empty)
                begin
                    if (mismatches < 10)
                        $display("box mismatch: exp org %0d %0d %0d len %0d %0d %0d empty %0b",
                                 want.origin_x, want.origin_y, want.origin_z,
                                 want.length_x, want.length_y, want.length_z,
                                 want.region_empty,
                                 ", got org %0d %0d %0d len %0d %0d %0d empty %0b",
                                 got.origin_x, got.origin_y, got.origin_z,
                                 got.length_x, got.length_y, got.length_z,
                                 got.region_empty);
                    mismatches++;
                end
            end
        end
        box_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    initial
    begin
        #(4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        voxel_ch.valid      = 1'b0;
        voxel_ch.voxel_x    = '0;
        voxel_ch.voxel_y    = '0;
        voxel_ch.voxel_z    = '0;
        voxel_ch.sample     = '0;
        voxel_ch.last_voxel = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_SELECT_MODE;
        cfg_ch.data         = '0;
        box_ch.ready        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_mask_mode();
        test_threshold_extremes();
        test_large_extent();

        src_idle_pct  = 30;
        sink_idle_pct <= 78;
        test_random(580);

        src_idle_pct  = 78;
        sink_idle_pct <= 30;
        test_random(580);

        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        test_backpressure();
        test_random(520);

        if (boxes_due.size() != 0)
        begin
            $display("%0d boxes never arrived", boxes_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fbb3d_pkg.sv
rtl/fbb3d_if.sv
rtl/foreground_bounding_box_3d_core.sv
test/tb_foreground_bounding_box_3d_core.sv
